// ----- rtl/mrr_pkg.sv -----
package mrr_pkg;

   // Fixed field widths.
   localparam int IDX_W     = 6;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 7;
   localparam int STEP_W    = 30;
   localparam int CSR_IDX_W = 2;

   // Internal coordinate, ring length and dividend widths (cover MAX_DIM up to 256).
   localparam int DIM_W = 9;
   localparam int LEN_W = 11;
   localparam int DIV_W = 31;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_STEPS = 2'd2;

   // Request modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // A classified request as it travels from the front to the back.
   typedef struct packed {
      logic                     mode;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
      logic                     in_range;
      logic                     wr_ok;
      logic                     rotate;
      logic [LEN_W-1:0]         pos;
      logic [LEN_W-1:0]         len;
      logic [DIM_W-1:0]         top;
      logic [DIM_W-1:0]         bottom;
      logic [DIM_W-1:0]         left;
      logic [DIM_W-1:0]         right;
      logic [DIM_W-1:0]         wl;
      logic [DIM_W-1:0]         hl;
   } item_type;

   // One stage of the modulo pipeline.
   typedef struct packed {
      logic             valid;
      item_type         item;
      logic [LEN_W-1:0] rem;
      logic [DIV_W-1:0] dvd;
   } stage_type;

endpackage

// ----- rtl/mrr_ram.sv -----
module mrr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read, held while disabled.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/mrr_front.sv -----
module mrr_front #(
   parameter int MAX_DIM = 64
) (
   input  logic [mrr_pkg::CNT_W-1:0]  row_count,
   input  logic [mrr_pkg::CNT_W-1:0]  col_count,
   input  logic                       mode,
   input  logic [mrr_pkg::IDX_W-1:0]  row,
   input  logic [mrr_pkg::IDX_W-1:0]  col,
   input  logic signed [mrr_pkg::DATA_W-1:0] value,
   output mrr_pkg::item_type          item
);
   import mrr_pkg::*;

   logic [DIM_W-1:0] rc, cc, rows, cols, r, c, max_d;
   logic [DIM_W-1:0] m_a, m_b, rr, cr, k;
   logic [DIM_W-1:0] top, bottom, left, right, h, w, wl, hl;
   logic [LEN_W-1:0] pos;

   assign max_d = DIM_W'(MAX_DIM);
   assign rc    = DIM_W'(row_count);
   assign cc    = DIM_W'(col_count);
   assign r     = DIM_W'(row);
   assign c     = DIM_W'(col);

   // Counts outside the legal range are clamped.
   assign rows = (rc < DIM_W'(2)) ? DIM_W'(2) : ((rc > max_d) ? max_d : rc);
   assign cols = (cc < DIM_W'(2)) ? DIM_W'(2) : ((cc > max_d) ? max_d : cc);

   // Ring index is the distance to the nearest edge.
   assign rr  = rows - DIM_W'(1) - r;
   assign cr  = cols - DIM_W'(1) - c;
   assign m_a = (r < c) ? r : c;
   assign m_b = (rr < cr) ? rr : cr;
   assign k   = (m_a < m_b) ? m_a : m_b;

   assign top    = k;
   assign left   = k;
   assign bottom = rows - DIM_W'(1) - k;
   assign right  = cols - DIM_W'(1) - k;
   assign h      = bottom - top + DIM_W'(1);
   assign w      = right - left + DIM_W'(1);
   assign wl     = w - DIM_W'(1);
   assign hl     = h - DIM_W'(1);

   // Clockwise position of the cell on its ring.
   always_comb begin
      if (r == top) begin
         pos = LEN_W'(c - left);
      end else if (c == right) begin
         pos = LEN_W'(wl) + LEN_W'(r - top);
      end else if (r == bottom) begin
         pos = LEN_W'(wl) + LEN_W'(hl) + LEN_W'(right - c);
      end else begin
         pos = (LEN_W'(wl) << 1) + LEN_W'(hl) + LEN_W'(bottom - r);
      end
   end

   // Pack the classified request.
   always_comb begin
      item.mode     = mode;
      item.row      = row;
      item.col      = col;
      item.value    = value;
      item.in_range = (r < rows) && (c < cols);
      item.wr_ok    = (r < max_d) && (c < max_d);
      item.rotate   = (h >= DIM_W'(2)) && (w >= DIM_W'(2));
      item.pos      = pos;
      item.len      = (LEN_W'(wl) << 1) + (LEN_W'(hl) << 1);
      item.top      = top;
      item.bottom   = bottom;
      item.left     = left;
      item.right    = right;
      item.wl       = wl;
      item.hl       = hl;
   end

endmodule

// ----- rtl/mrr_queue.sv -----
module mrr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mrr_pkg::item_type push_item,
   output logic              not_full,
   input  logic              pop,
   output logic              not_empty,
   output mrr_pkg::item_type pop_item
);
   import mrr_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/mrr_back.sv -----
module mrr_back #(
   parameter int MAX_DIM = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mrr_pkg::STEP_W-1:0] rotation_steps,
   input  logic                       q_valid,
   input  mrr_pkg::item_type          q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [mrr_pkg::DATA_W-1:0] rsp_value_res,
   output logic [mrr_pkg::IDX_W-1:0]  rsp_row_res,
   output logic [mrr_pkg::IDX_W-1:0]  rsp_col_res
);
   import mrr_pkg::*;

   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   stage_type        stage_ff [DIV_W+1];
   stage_type        stage_in [DIV_W+1];
   logic             advance;
   stage_type        s;
   logic [LEN_W-1:0] q;
   logic [DIM_W-1:0] sr, sc;
   logic [2*DIM_W-1:0] full_addr;
   logic [AW-1:0]    addr;
   logic             we;
   logic [DATA_W-1:0] rdata;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_zero_ff;
   logic [IDX_W-1:0] rsp_row_ff, rsp_col_ff;

   // The whole back end moves only when the output register can take a result.
   assign advance = !rsp_valid_ff || rsp_ready;
   assign q_pop   = advance && q_valid;

   // Restoring modulo: one dividend bit per stage.
   always_comb begin
      logic [LEN_W:0] shifted;
      shifted            = '0;
      stage_in[0].valid  = q_valid;
      stage_in[0].item   = q_item;
      stage_in[0].rem    = '0;
      stage_in[0].dvd    = DIV_W'(q_item.pos) + DIV_W'(rotation_steps);
      for (int i = 0; i < DIV_W; i++) begin
         stage_in[i+1] = stage_ff[i];
         shifted = {stage_ff[i].rem, stage_ff[i].dvd[DIV_W-1]};
         if (shifted >= {1'b0, stage_ff[i].item.len}) begin
            shifted = shifted - {1'b0, stage_ff[i].item.len};
         end
         stage_in[i+1].rem = shifted[LEN_W-1:0];
         stage_in[i+1].dvd = stage_ff[i].dvd << 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_W; i++) begin
         if (reset) begin
            stage_ff[i].valid <= 1'b0;
         end else if (advance) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   // Map the rotated position back to a cell.
   assign s = stage_ff[DIV_W];
   assign q = s.rem;

   always_comb begin
      sr = DIM_W'(s.item.row);
      sc = DIM_W'(s.item.col);
      if (s.item.mode == MODE_READ && s.item.in_range && s.item.rotate) begin
         if (q < LEN_W'(s.item.wl)) begin
            sr = s.item.top;
            sc = s.item.left + DIM_W'(q);
         end else if (q < LEN_W'(s.item.wl) + LEN_W'(s.item.hl)) begin
            sr = s.item.top + DIM_W'(q - LEN_W'(s.item.wl));
            sc = s.item.right;
         end else if (q < (LEN_W'(s.item.wl) << 1) + LEN_W'(s.item.hl)) begin
            sr = s.item.bottom;
            sc = s.item.right - DIM_W'(q - LEN_W'(s.item.wl) - LEN_W'(s.item.hl));
         end else begin
            sr = s.item.bottom
               - DIM_W'(q - (LEN_W'(s.item.wl) << 1) - LEN_W'(s.item.hl));
            sc = s.item.left;
         end
      end
   end

   assign full_addr = (2*DIM_W)'(sr) * (2*DIM_W)'(MAX_DIM) + (2*DIM_W)'(sc);
   assign addr      = full_addr[AW-1:0];
   assign we        = s.valid && (s.item.mode == MODE_WRITE) && s.item.wr_ok;

   // Matrix store.
   mrr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_DIM * MAX_DIM)
   ) u_store (
      .clock (clock),
      .en    (advance),
      .we    (we),
      .addr  (addr),
      .wdata (s.item.value),
      .rdata (rdata)
   );

   // Output register alongside the store's read register.
   always_comb begin
      if (advance) begin
         rsp_valid_in = s.valid && (s.item.mode == MODE_READ);
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_zero_ff <= !s.item.in_range;
         rsp_row_ff  <= s.item.row;
         rsp_col_ff  <= s.item.col;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_zero_ff ? '0 : rdata;
   assign rsp_row_res   = rsp_row_ff;
   assign rsp_col_res   = rsp_col_ff;

endmodule

// ----- rtl/matrix_ring_rotator_core.sv -----
// Matrix ring rotator.
// Requests arrive on the req_ channel. A write request (mode 0) stores value at
// (row, col) and gives no response. A read request (mode 1) returns on the rsp_
// channel the element seen at (row, col) once every ring of the matrix has been
// turned counter-clockwise by rotation_steps; cells outside the rows and
// columns in use read as zero. Responses come back in request order.
// Registers row_count, col_count and rotation_steps are written over the csr_
// port, which is always ready; the user must write them only while no request
// is outstanding, as the block does not enforce it. The front end classifies
// each request in the cycle it is accepted and places it in a two-entry queue.
// The back end computes the ring position modulo the ring length with an input
// register and a 31-stage pipeline, one dividend bit per stage, then reads or
// writes the matrix store. One request per cycle is sustained unless stalled.
// When the receiver stalls, the whole back end holds; the queue then fills and
// req_ready drops once both of its entries are taken. Reset clears the
// pipeline, the queue and the registers; the matrix store is not cleared and a
// cell must be written before it is read.
module matrix_ring_rotator_core #(
   parameter int MAX_DIM = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [mrr_pkg::IDX_W-1:0]         req_row,
   input  logic [mrr_pkg::IDX_W-1:0]         req_col,
   input  logic signed [mrr_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mrr_pkg::DATA_W-1:0] rsp_value_res,
   output logic [mrr_pkg::IDX_W-1:0]         rsp_row_res,
   output logic [mrr_pkg::IDX_W-1:0]         rsp_col_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mrr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrr_pkg::STEP_W-1:0]        csr_data
);
   import mrr_pkg::*;

   logic [CNT_W-1:0]  row_count_ff, col_count_ff;
   logic [STEP_W-1:0] rotation_steps_ff;
   item_type          front_item, q_item;
   logic              q_not_full, q_valid, q_pop, push;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= CNT_W'(2);
         col_count_ff      <= CNT_W'(2);
         rotation_steps_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_COUNT: row_count_ff      <= csr_data[CNT_W-1:0];
            CSR_COL_COUNT: col_count_ff      <= csr_data[CNT_W-1:0];
            CSR_ROT_STEPS: rotation_steps_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Front end: classify the request.
   mrr_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .mode      (req_mode),
      .row       (req_row),
      .col       (req_col),
      .value     (req_value),
      .item      (front_item)
   );

   assign req_ready = q_not_full;
   assign push      = req_valid && q_not_full;

   // Queue between the two halves.
   mrr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_item)
   );

   // Back end: modulo pipeline and matrix store.
   mrr_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .rotation_steps (rotation_steps_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_res  (rsp_value_res),
      .rsp_row_res    (rsp_row_res),
      .rsp_col_res    (rsp_col_res)
   );

endmodule
